// ===== hdl/trd_pkg.sv =====
// shared types, codes and constants of the touch report decoder
package trd_pkg;

    // field widths fixed by the frame format
    localparam int COORD_BITS    = 12;
    localparam int PRESS_BITS    = 7;
    localparam int SLOT_BITS     = 4;
    localparam int SLOT_IDS      = 16;
    localparam int SLOT_CNT_W    = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int MAX_SLOTS_DEF = 10;

    // register reset values
    localparam logic [SLOT_BITS-1:0]  TOUCH_LIMIT_RST = 4'd10;
    localparam logic [COORD_BITS-1:0] LIMIT_X_RST     = 12'd1200;
    localparam logic [COORD_BITS-1:0] LIMIT_Y_RST     = 12'd1920;

    // input item operations
    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_RECORD = 2'd1,
        OP_END    = 2'd2
    } t_op;

    // result kinds
    typedef enum logic [1:0] {
        KIND_CONTACT = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_SYNC    = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOUCH_LIMIT = 3'd0,
        CFG_LIMIT_X     = 3'd1,
        CFG_LIMIT_Y     = 3'd2,
        CFG_SWAP_AXES   = 3'd3,
        CFG_FLIP_X      = 3'd4,
        CFG_FLIP_Y      = 3'd5
    } t_cfg_idx;

    // touch event codes in bits 7:6 of the first record byte
    localparam logic [1:0] EVT_DOWN    = 2'd0;
    localparam logic [1:0] EVT_CONTACT = 2'd2;

    // input item payload
    typedef struct packed {
        t_op        op;
        logic [7:0] count_byte;
        logic [7:0] rec_byte0;
        logic [7:0] rec_byte1;
        logic [7:0] rec_byte2;
        logic [7:0] rec_byte3;
        logic [7:0] rec_byte4;
    } t_in;

    // result item payload
    typedef struct packed {
        t_kind                 kind;
        logic [SLOT_BITS-1:0]  slot;
        logic                  touching;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [PRESS_BITS-1:0] pressure;
        logic                  last;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic frame_start;
        logic record;
        logic scan_init;
        logic advance;
        logic frame_clear;
        logic load_contact;
        logic load_release;
        logic load_sync;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic rec_emit;
        logic scan_end;
        logic cur_seen;
    } t_stat;

endpackage

// ===== hdl/trd_ctrl.sv =====
// controller state machine: input and output handshakes, frame end slot scan
module trd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  trd_pkg::t_op  i_op,
    input  logic          i_out_ready,
    input  trd_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output trd_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_in_xfer;
    logic   w_load;

    // output register can take a new result this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_load     = o_cmd.load_contact || o_cmd.load_release || o_cmd.load_sync;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    case (i_op)
                        trd_pkg::OP_START: begin
                            o_cmd.frame_start = 1'b1;
                        end
                        trd_pkg::OP_RECORD: begin
                            o_cmd.record       = 1'b1;
                            o_cmd.load_contact = i_stat.rec_emit;
                        end
                        trd_pkg::OP_END: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // one slot per cycle while the output register is free, then the sync
                if (w_out_free) begin
                    if (i_stat.scan_end) begin
                        o_cmd.load_sync   = 1'b1;
                        o_cmd.frame_clear = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.advance      = 1'b1;
                        o_cmd.load_release = !i_stat.cur_seen;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/trd_dp.sv =====
// datapath: config registers, frame state, coordinate transform, result register
module trd_dp #(
    parameter int MAX_SLOTS = trd_pkg::MAX_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  trd_pkg::t_in                        i_in,
    input  trd_pkg::t_cmd                       i_cmd,
    output trd_pkg::t_stat                      o_stat,
    output trd_pkg::t_out                       o_out
);

    localparam int CB = trd_pkg::COORD_BITS;
    localparam int SB = trd_pkg::SLOT_BITS;
    localparam int NW = trd_pkg::SLOT_CNT_W;

    // transformed coordinate clamped to [0, limit]
    function automatic logic [CB-1:0] f_xform(
        input logic [CB-1:0] v,
        input logic [CB-1:0] lim,
        input logic          flip
    );
        logic [CB:0] t;
        begin
            t = flip ? ({1'b0, lim} - {1'b0, v}) : {1'b0, v};
            if (t[CB]) begin
                f_xform = '0;
            end else if (t[CB-1:0] > lim) begin
                f_xform = lim;
            end else begin
                f_xform = t[CB-1:0];
            end
        end
    endfunction

    logic [SB-1:0]        r_touch_limit;
    logic [CB-1:0]        r_limit_x;
    logic [CB-1:0]        r_limit_y;
    logic                 r_swap_axes;
    logic                 r_flip_x;
    logic                 r_flip_y;
    logic [MAX_SLOTS-1:0] r_seen;
    logic [SB-1:0]        r_left;
    logic [NW-1:0]        r_idx;
    trd_pkg::t_out        r_out, n_out;

    logic [NW-1:0]                 w_nslots;
    logic [SB-1:0]                 w_id;
    logic [SB-1:0]                 w_cnt;
    logic [SB-1:0]                 w_left_start;
    logic [trd_pkg::SLOT_IDS-1:0]  w_seen_ext;
    logic [MAX_SLOTS-1:0]          w_mark;
    logic [CB-1:0]                 w_x, w_y, w_xs, w_ys, w_xl, w_yl;
    logic [1:0]                    w_event;
    logic                          w_touching;
    trd_pkg::t_out                 w_contact;

    // slots in use, saturated at the slot count
    assign w_nslots = ({1'b0, r_touch_limit} > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS)
                                                               : {1'b0, r_touch_limit};

    // record fields
    assign w_event    = i_in.rec_byte0[7:6];
    assign w_id       = i_in.rec_byte2[7:4];
    assign w_x        = {i_in.rec_byte0[3:0], i_in.rec_byte1};
    assign w_y        = {i_in.rec_byte2[3:0], i_in.rec_byte3};
    assign w_touching = (w_event == trd_pkg::EVT_DOWN) || (w_event == trd_pkg::EVT_CONTACT);
    assign w_cnt      = i_in.count_byte[3:0];
    assign w_left_start = ({1'b0, w_cnt} < w_nslots) ? w_cnt : w_nslots[SB-1:0];

    // swap axes and limits
    assign w_xs = r_swap_axes ? w_y : w_x;
    assign w_ys = r_swap_axes ? w_x : w_y;
    assign w_xl = r_swap_axes ? r_limit_y : r_limit_x;
    assign w_yl = r_swap_axes ? r_limit_x : r_limit_y;

    // contact result
    always_comb begin
        w_contact          = '0;
        w_contact.kind     = trd_pkg::KIND_CONTACT;
        w_contact.slot     = w_id;
        w_contact.touching = w_touching;
        w_contact.last     = 1'b1;
        if (w_touching) begin
            w_contact.pos_x    = f_xform(w_xs, w_xl, r_flip_x);
            w_contact.pos_y    = f_xform(w_ys, w_yl, r_flip_y);
            w_contact.pressure = i_in.rec_byte4[trd_pkg::PRESS_BITS-1:0];
        end
    end

    // seen mask lookup and mark
    assign w_seen_ext = trd_pkg::SLOT_IDS'(r_seen);
    assign w_mark     = MAX_SLOTS'(trd_pkg::SLOT_IDS'(1) << w_id);

    // status
    assign o_stat.rec_emit = (r_left != '0) && ({1'b0, w_id} < w_nslots);
    assign o_stat.scan_end = (r_idx >= w_nslots);
    assign o_stat.cur_seen = w_seen_ext[r_idx[SB-1:0]];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_limit <= trd_pkg::TOUCH_LIMIT_RST;
            r_limit_x     <= trd_pkg::LIMIT_X_RST;
            r_limit_y     <= trd_pkg::LIMIT_Y_RST;
            r_swap_axes   <= 1'b0;
            r_flip_x      <= 1'b0;
            r_flip_y      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                trd_pkg::CFG_TOUCH_LIMIT: r_touch_limit <= i_cfg_data[SB-1:0];
                trd_pkg::CFG_LIMIT_X:     r_limit_x     <= i_cfg_data[CB-1:0];
                trd_pkg::CFG_LIMIT_Y:     r_limit_y     <= i_cfg_data[CB-1:0];
                trd_pkg::CFG_SWAP_AXES:   r_swap_axes   <= i_cfg_data[0];
                trd_pkg::CFG_FLIP_X:      r_flip_x      <= i_cfg_data[0];
                trd_pkg::CFG_FLIP_Y:      r_flip_y      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // frame state: seen mask and records left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_left <= '0;
        end else if (i_cmd.frame_start) begin
            r_seen <= '0;
            r_left <= w_left_start;
        end else if (i_cmd.frame_clear) begin
            r_seen <= '0;
            r_left <= '0;
        end else if (i_cmd.record && (r_left != '0)) begin
            r_left <= r_left - SB'(1);
            if (o_stat.rec_emit) begin
                r_seen <= r_seen | w_mark;
            end
        end
    end

    // slot scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.scan_init) begin
            r_idx <= '0;
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + NW'(1);
        end
    end

    // result register next value
    always_comb begin
        n_out = r_out;
        if (i_cmd.load_contact) begin
            n_out = w_contact;
        end else if (i_cmd.load_release) begin
            n_out      = '0;
            n_out.kind = trd_pkg::KIND_RELEASE;
            n_out.slot = r_idx[SB-1:0];
        end else if (i_cmd.load_sync) begin
            n_out      = '0;
            n_out.kind = trd_pkg::KIND_SYNC;
            n_out.last = 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

// ===== hdl/touch_report_decoder_unit.sv =====
// top level of the touch report decoder: controller, datapath and checks
//
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_ready       i_in   (trd_pkg::t_in)
//  out       output     o_out_valid / i_out_ready     o_out  (trd_pkg::t_out)
//  cfg       input      i_cfg_we, no wait             i_cfg_idx, i_cfg_data
//
// frame start and point records leave the controller idle; a record result sits in
// the output register in the cycle after its transfer.
// frame end keeps the input stalled while the slot scan runs: one slot per cycle
// while the output is not stalled, then the sync.
// input is taken only while no scan runs and the output register is free.
// reset is synchronous, active low; no clearing pass is needed.
module touch_report_decoder_unit #(
    parameter int MAX_SLOTS = trd_pkg::MAX_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  trd_pkg::t_in                    i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output trd_pkg::t_out                   o_out,
    input  logic                            i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    trd_pkg::t_cmd  w_cmd;
    trd_pkg::t_stat w_stat;

    // controller
    trd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in.op),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // datapath
    trd_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    // at most one result load per cycle
    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_contact, w_cmd.load_release, w_cmd.load_sync}))
        else $error("more than one result load in a cycle");

    // a result is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_contact || w_cmd.load_release || w_cmd.load_sync)
            |-> (!o_out_valid || i_out_ready))
        else $error("result load overwrites a pending transfer");

    // the sync shows up next cycle as the last result of its frame end
    a_sync_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_sync |=> (o_out_valid && o_out.last
                             && (o_out.kind == trd_pkg::KIND_SYNC)))
        else $error("sync result missing or not marked last");

    // no input transfer while the slot scan runs
    a_no_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(w_cmd.advance || w_cmd.load_sync))
        else $error("input taken during slot scan");
`endif

endmodule

// ===== test/touch_report_decoder_checker.sv =====
// scoreboard for the touch report decoder: watches the channels, predicts reports and compares
module touch_report_decoder_checker #(
    parameter int MAX_SLOTS = trd_pkg::MAX_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  trd_pkg::t_in                    i_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  trd_pkg::t_out                   i_out,
    input  logic                            i_cfg_we,
    input  logic [trd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [trd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import trd_pkg::*;

    // shadow registers and frame state
    logic [SLOT_BITS-1:0]  touch_lim;
    logic [COORD_BITS-1:0] lim_x;
    logic [COORD_BITS-1:0] lim_y;
    logic                  swap_xy;
    logic                  inv_x;
    logic                  inv_y;
    logic [SLOT_IDS-1:0]   seen_mask;
    int                    recs_left;

    // reports still owed by the block, oldest first
    t_out report_q[$];
    int   mismatches = 0;

    function automatic int slots_active();
        return (int'(touch_lim) > MAX_SLOTS) ? MAX_SLOTS : int'(touch_lim);
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0) return 0;
        return (v > hi) ? hi : v;
    endfunction

    function automatic t_out make_report(t_kind k, int slot, logic touch, int px, int py,
                                         int pr, logic fin);
        t_out r;
        r.kind     = k;
        r.slot     = slot[SLOT_BITS-1:0];
        r.touching = touch;
        r.pos_x    = px[COORD_BITS-1:0];
        r.pos_y    = py[COORD_BITS-1:0];
        r.pressure = pr[PRESS_BITS-1:0];
        r.last     = fin;
        return r;
    endfunction

    // queue the reports that one input transfer causes
    function automatic void predict_reports(t_in it);
        int         nslots;
        int         id;
        int         x;
        int         y;
        int         xl;
        int         yl;
        int         tmp;
        int         cnt;
        logic [1:0] ev;
        logic       touch;
        nslots = slots_active();
        case (it.op)
            OP_START: begin
                cnt       = int'(it.count_byte[3:0]);
                recs_left = (cnt < nslots) ? cnt : nslots;
                seen_mask = '0;
            end
            OP_RECORD: begin
                if (recs_left != 0) begin
                    recs_left--;
                    id = int'(it.rec_byte2[7:4]);
                    if (id < nslots) begin
                        ev    = it.rec_byte0[7:6];
                        touch = (ev == EVT_DOWN) || (ev == EVT_CONTACT);
                        x     = int'({it.rec_byte0[3:0], it.rec_byte1});
                        y     = int'({it.rec_byte2[3:0], it.rec_byte3});
                        xl    = swap_xy ? int'(lim_y) : int'(lim_x);
                        yl    = swap_xy ? int'(lim_x) : int'(lim_y);
                        if (swap_xy) begin
                            tmp = x;
                            x   = y;
                            y   = tmp;
                        end
                        if (inv_x) x = xl - x;
                        if (inv_y) y = yl - y;
                        seen_mask[id] = 1'b1;
                        if (touch) begin
                            report_q.push_back(make_report(KIND_CONTACT, id, 1'b1,
                                clamp_coord(x, xl), clamp_coord(y, yl),
                                int'(it.rec_byte4[6:0]), 1'b1));
                        end else begin
                            report_q.push_back(make_report(KIND_CONTACT, id, 1'b0,
                                0, 0, 0, 1'b1));
                        end
                    end
                end
            end
            OP_END: begin
                // release every slot in use that no record touched, then sync
                for (int i = 0; i < nslots; i++) begin
                    if (!seen_mask[i])
                        report_q.push_back(make_report(KIND_RELEASE, i, 1'b0, 0, 0, 0, 1'b0));
                end
                report_q.push_back(make_report(KIND_SYNC, 0, 1'b0, 0, 0, 0, 1'b1));
                seen_mask = '0;
                recs_left = 0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // compare one output transfer with the oldest owed report
    function automatic void check_report(t_out got);
        t_out want;
        if (report_q.size() == 0) begin
            $display("%0t: unexpected report, expected none, got %h", $time, got);
            mismatches++;
        end else begin
            want = report_q.pop_front();
            check_field("kind", int'(want.kind), int'(got.kind));
            check_field("slot", 32'(want.slot), 32'(got.slot));
            check_field("touching", 32'(want.touching), 32'(got.touching));
            check_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
            check_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
            check_field("pressure", 32'(want.pressure), 32'(got.pressure));
            check_field("last", 32'(want.last), 32'(got.last));
        end
    endfunction

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            touch_lim = TOUCH_LIMIT_RST;
            lim_x     = LIMIT_X_RST;
            lim_y     = LIMIT_Y_RST;
            swap_xy   = 1'b0;
            inv_x     = 1'b0;
            inv_y     = 1'b0;
            seen_mask = '0;
            recs_left = 0;
            report_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_report(i_out);
            if (i_in_valid && i_in_ready) predict_reports(i_in);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TOUCH_LIMIT: touch_lim = i_cfg_data[SLOT_BITS-1:0];
                    CFG_LIMIT_X:     lim_x     = i_cfg_data[COORD_BITS-1:0];
                    CFG_LIMIT_Y:     lim_y     = i_cfg_data[COORD_BITS-1:0];
                    CFG_SWAP_AXES:   swap_xy   = i_cfg_data[0];
                    CFG_FLIP_X:      inv_x     = i_cfg_data[0];
                    CFG_FLIP_Y:      inv_y     = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        o_pending    <= report_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== test/touch_report_decoder_unit_test.sv =====
// testbench top of the touch report decoder: clock, reset, stimulus and verdict
module touch_report_decoder_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import trd_pkg::*;

    localparam int MAX_SLOTS    = MAX_SLOTS_DEF;
    localparam int DRAIN_CYCLES = MAX_SLOTS + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 216;
    localparam int PHASES       = 6;
    localparam int LONG_HOLD    = 200;
    localparam int HOLD_AT_XFER = 60;

    // lifted event codes and the unused operation
    localparam logic [1:0] EVT_LIFT = 2'd1;
    localparam logic [1:0] EVT_IDLE = 2'd3;
    localparam logic [1:0] OP_NOP   = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in                   in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out                  out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;

    int                    slots_used;
    int                    items_sent;
    int                    cycles;
    int                    out_xfers;
    logic                  burst;

    touch_report_decoder_unit #(
        .MAX_SLOTS(MAX_SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    touch_report_decoder_checker #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // report receiver: random gaps, one long hold-off to back up the block
    initial begin
        int gap;
        out_ready = 1'b0;
        out_xfers = 0;
        while (rst_n !== 1'b1) @(negedge clk);
        forever begin
            gap = burst ? 0 : $urandom_range(0, 3);
            if (out_xfers == HOLD_AT_XFER) gap = LONG_HOLD;
            if (gap != 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            out_xfers++;
            @(negedge clk);
        end
    end

    // one input transfer; valid stays high afterwards until the next item or idle
    task automatic send_item(t_in item);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = item;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (item.op != t_op'(OP_NOP)) items_sent++;
    endtask

    function automatic t_in start_item(logic [7:0] cnt);
        t_in it;
        it            = '0;
        it.op         = OP_START;
        it.count_byte = cnt;
        it.rec_byte0  = 8'($urandom);
        it.rec_byte4  = 8'($urandom);
        return it;
    endfunction

    function automatic t_in end_item();
        t_in it;
        it            = '0;
        it.op         = OP_END;
        it.count_byte = 8'($urandom);
        it.rec_byte2  = 8'($urandom);
        return it;
    endfunction

    function automatic t_in record_item(logic [3:0] id, logic [1:0] ev, logic [11:0] x,
                                        logic [11:0] y, logic [7:0] pr);
        t_in        it;
        logic [1:0] pad;
        pad           = 2'($urandom);
        it.op         = OP_RECORD;
        it.count_byte = 8'($urandom);
        it.rec_byte0  = {ev, pad, x[11:8]};
        it.rec_byte1  = x[7:0];
        it.rec_byte2  = {id, y[11:8]};
        it.rec_byte3  = y[7:0];
        it.rec_byte4  = pr;
        return it;
    endfunction

    function automatic logic [11:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 12'd0;
            1:       return 12'd4095;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_idx  = idx;
        cfg_data = val;
        cfg_we   = 1'b1;
        @(negedge clk);
    endtask

    task automatic set_config(int tl, logic [11:0] lx, logic [11:0] ly, logic sw, logic fx,
                              logic fy);
        write_reg(CFG_TOUCH_LIMIT, 12'(tl));
        write_reg(CFG_LIMIT_X, lx);
        write_reg(CFG_LIMIT_Y, ly);
        write_reg(CFG_SWAP_AXES, 12'(sw));
        write_reg(CFG_FLIP_X, 12'(fx));
        write_reg(CFG_FLIP_Y, 12'(fy));
        cfg_we     = 1'b0;
        slots_used = (tl > MAX_SLOTS) ? MAX_SLOTS : tl;
    endtask

    // wait until every owed report has arrived and the scan is surely over
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // mostly well-formed frames with random content, some broken or noise items
    task automatic random_frame();
        t_in        it;
        logic [7:0] cnt;
        int         avail;
        int         nrec;
        logic [3:0] id;
        logic       no_start;
        if ($urandom_range(0, 7) == 0) burst = ~burst;
        if ($urandom_range(0, 9) == 0) begin
            it.op         = t_op'($urandom_range(0, 3));
            it.count_byte = 8'($urandom);
            it.rec_byte0  = 8'($urandom);
            it.rec_byte1  = 8'($urandom);
            it.rec_byte2  = 8'($urandom);
            it.rec_byte3  = 8'($urandom);
            it.rec_byte4  = 8'($urandom);
            send_item(it);
            return;
        end
        cnt      = 8'($urandom);
        avail    = (int'(cnt[3:0]) < slots_used) ? int'(cnt[3:0]) : slots_used;
        nrec     = avail;
        no_start = 1'b0;
        case ($urandom_range(0, 7))
            0:       nrec = avail + 1;
            1:       nrec = (avail > 0) ? avail - 1 : 0;
            2:       no_start = 1'b1;
            default: ;
        endcase
        if (!no_start) send_item(start_item(cnt));
        for (int i = 0; i < nrec; i++) begin
            if ($urandom_range(0, 5) == 0) id = 4'($urandom);
            else id = 4'($urandom_range(0, slots_used - 1));
            send_item(record_item(id, 2'($urandom), rand_coord(), rand_coord(),
                                  8'($urandom)));
        end
        if ($urandom_range(0, 9) != 0) send_item(end_item());
    endtask

    // stimulus and verdict
    initial begin
        int       quota;
        t_in      nop;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_we     = 1'b0;
        cfg_idx    = CFG_TOUCH_LIMIT;
        cfg_data   = '0;
        burst      = 1'b0;
        items_sent = 0;
        slots_used = MAX_SLOTS;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed frames at reset settings
        send_item(end_item());
        send_item(start_item(8'hF5));
        send_item(record_item(4'd0, EVT_DOWN, 12'd0, 12'd0, 8'd0));
        send_item(record_item(4'd9, EVT_CONTACT, 12'd4095, 12'd4095, 8'hFF));
        send_item(record_item(4'd3, EVT_LIFT, 12'd100, 12'd200, 8'd50));
        send_item(record_item(4'd12, EVT_IDLE, 12'd5, 12'd6, 8'd7));
        send_item(record_item(4'd5, EVT_CONTACT, 12'd1199, 12'd1921, 8'h7F));
        send_item(record_item(4'd1, EVT_DOWN, 12'd10, 12'd10, 8'd10));
        nop    = end_item();
        nop.op = t_op'(OP_NOP);
        send_item(nop);
        send_item(end_item());
        send_item(start_item(8'h00));
        send_item(record_item(4'd2, EVT_DOWN, 12'd1, 12'd1, 8'd1));
        send_item(end_item());
        send_item(start_item(8'hAF));
        send_item(record_item(4'd7, EVT_DOWN, 12'd2048, 12'd1024, 8'd64));
        send_item(record_item(4'd8, EVT_IDLE, 12'd3000, 12'd3000, 8'd127));
        send_item(record_item(4'd4, EVT_CONTACT, 12'd1200, 12'd1920, 8'd1));
        send_item(end_item());
        settle();

        // random phases, the first two at the register extremes
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       set_config(1, 12'd0, 12'd0, 1'b1, 1'b1, 1'b1);
                1:       set_config(15, 12'd4095, 12'd4095, 1'b0, 1'b0, 1'b0);
                2:       set_config(10, 12'd1200, 12'd1920, 1'b1, 1'b0, 1'b1);
                default: set_config($urandom_range(1, 15), rand_coord(), rand_coord(),
                                    1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            quota = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < quota) random_frame();
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
